FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/ial_pkg.sv
// ---------------------------------------------------------------------------
// ial_pkg
// Shared constants and types of the indexed array list.
// ---------------------------------------------------------------------------
`default_nettype none

package ial_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int OP_BITS    = 3;
	localparam int POS_BITS   = 4;
	localparam int IN_BITS    = 32;
	localparam int OUT_BITS   = 32;
	localparam int COUNT_BITS = 5;
	localparam int ST_BITS    = 2;

	localparam logic [OP_BITS-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_BITS-1:0] OP_POP    = 3'd3;
	localparam logic [OP_BITS-1:0] OP_READ   = 3'd4;

	localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_BITS-1:0] ST_FULL  = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic execute;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ial_ctrl.sv
// ---------------------------------------------------------------------------
// ial_ctrl
// Request sequencing: request register occupancy and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module ial_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ial_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_exec;

	assign can_exec    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE) || can_exec;
	assign cmd.load_req = in_valid && in_ready;
	assign cmd.execute  = (state_q == S_EXEC) && can_exec;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// a new request can enter while the held one executes
				if (can_exec) begin
					state_d = in_valid ? S_EXEC : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ial_dp.sv
// ---------------------------------------------------------------------------
// ial_dp
// Request register, row of shifting element cells, count and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ial_dp #(
	parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ial_pkg::VALUE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ial_pkg::ctrl_cmd_t                cmd,
	input  wire logic [ial_pkg::OP_BITS-1:0]       operation,
	input  wire logic [ial_pkg::POS_BITS-1:0]      position,
	input  wire logic [ial_pkg::IN_BITS-1:0]       element_value,
	output logic      [ial_pkg::OUT_BITS-1:0]      read_value,
	output logic      [ial_pkg::COUNT_BITS-1:0]    element_count,
	output logic      [ial_pkg::ST_BITS-1:0]       status
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int PW   = $clog2(CAPACITY);
	localparam int CMPW = ((CW > ial_pkg::POS_BITS) ? CW : ial_pkg::POS_BITS) + 1;

	logic [ial_pkg::OP_BITS-1:0]  op_q;
	logic [ial_pkg::POS_BITS-1:0] pos_q;
	logic [VALUE_BITS-1:0]        val_q;
	logic [CW-1:0]                count_q;

	logic [VALUE_BITS-1:0] cells_q [CAPACITY];

	logic [ial_pkg::OUT_BITS-1:0]   read_value_q;
	logic [ial_pkg::COUNT_BITS-1:0] element_count_q;
	logic [ial_pkg::ST_BITS-1:0]    status_q;

	logic [CMPW-1:0]             cnt_ext;
	logic [CMPW-1:0]             pos_ext;
	logic [CMPW-1:0]             tgt;
	logic                        put_ok;
	logic                        take_ok;
	logic                        rd_ok;
	logic [ial_pkg::ST_BITS-1:0] st;
	logic [CW-1:0]               count_d;
	logic [PW-1:0]               rd_idx;

	assign cnt_ext = CMPW'(count_q);
	assign pos_ext = CMPW'(pos_q);
	assign rd_idx  = pos_ext[PW-1:0];

	always_comb begin
		tgt     = pos_ext;
		put_ok  = 1'b0;
		take_ok = 1'b0;
		rd_ok   = 1'b0;
		st      = ial_pkg::ST_OK;
		unique case (op_q)
			ial_pkg::OP_APPEND, ial_pkg::OP_INSERT: begin
				if (op_q == ial_pkg::OP_APPEND) begin
					tgt = cnt_ext;
				end
				// range test precedes full test
				if (tgt > cnt_ext) begin
					st = ial_pkg::ST_RANGE;
				end else if (cnt_ext == CMPW'(CAPACITY)) begin
					st = ial_pkg::ST_FULL;
				end else begin
					put_ok = 1'b1;
				end
			end
			ial_pkg::OP_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					st = ial_pkg::ST_RANGE;
				end else begin
					take_ok = 1'b1;
				end
			end
			ial_pkg::OP_POP: begin
				tgt = cnt_ext - CMPW'(1);
				if (count_q == '0) begin
					st = ial_pkg::ST_EMPTY;
				end else begin
					take_ok = 1'b1;
				end
			end
			ial_pkg::OP_READ: begin
				if (pos_ext >= cnt_ext || pos_ext >= CMPW'(CAPACITY)) begin
					st = ial_pkg::ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				st = ial_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (put_ok) begin
			count_d = count_q + CW'(1);
		end else if (take_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= operation;
			pos_q <= position;
			val_q <= VALUE_BITS'(element_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_d;
		end
	end

	// each cell takes its own value, the new value, or a neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] up_src;
		logic [VALUE_BITS-1:0] down_src;
		if (i > 0) begin : g_up
			assign up_src = cells_q[i-1];
		end else begin : g_up0
			assign up_src = cells_q[i];
		end
		if (i < CAPACITY - 1) begin : g_dn
			assign down_src = cells_q[i+1];
		end else begin : g_dn_last
			assign down_src = cells_q[i];
		end
		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				if (put_ok && CMPW'(i) == tgt) begin
					cells_q[i] <= val_q;
				end else if (put_ok && CMPW'(i) > tgt) begin
					cells_q[i] <= up_src;
				end else if (take_ok && CMPW'(i) >= tgt) begin
					cells_q[i] <= down_src;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			read_value_q    <= rd_ok ? ial_pkg::OUT_BITS'(cells_q[rd_idx]) : '0;
			element_count_q <= ial_pkg::COUNT_BITS'(count_d);
			status_q        <= st;
		end
	end

	assign read_value    = read_value_q;
	assign element_count = element_count_q;
	assign status        = status_q;

endmodule

`default_nettype wire

FILE: rtl/indexed_array_list.sv
// ---------------------------------------------------------------------------
// indexed_array_list
// Ordered list with append, insert, remove, pop and read at index.
// Flow: an accepted request is held in the request register, then executed into the result register.
// Throughput: one request per cycle while the output is not stalled; every cell shifts in parallel.
// Reset: count cleared and no result pending; element cells are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module indexed_array_list #(
	parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ial_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ial_pkg::OP_BITS-1:0]     operation,
	input  wire logic [ial_pkg::POS_BITS-1:0]    position,
	input  wire logic [ial_pkg::IN_BITS-1:0]     element_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ial_pkg::OUT_BITS-1:0]    read_value,
	output logic      [ial_pkg::COUNT_BITS-1:0]  element_count,
	output logic      [ial_pkg::ST_BITS-1:0]     status
);

	ial_pkg::ctrl_cmd_t cmd;

	ial_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ial_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.position      (position),
		.element_value (element_value),
		.read_value    (read_value),
		.element_count (element_count),
		.status        (status)
	);

	`ASSERT_IMPLIES(a_full_count, clk, arst_n, out_valid && status == ial_pkg::ST_FULL, element_count == ial_pkg::COUNT_BITS'(CAPACITY))
	`ASSERT_IMPLIES(a_empty_count, clk, arst_n, out_valid && status == ial_pkg::ST_EMPTY, element_count == '0)
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, out_valid && status != ial_pkg::ST_OK, read_value == '0)
	`ASSERT_NEXT(a_exec_valid, clk, arst_n, cmd.execute, out_valid)

endmodule

`default_nettype wire
